// ----- rtl/pps_pkg.sv -----
package pps_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  label;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [31:0] arrival;
        logic [7:0]  urgency;
    } t_entry;

    typedef struct packed {
        logic        ran;
        logic [7:0]  served_label;
        logic        first_service;
        logic [31:0] response_ticks;
        logic        finished;
        logic [31:0] turnaround_ticks;
        logic [31:0] waiting_ticks;
        logic [31:0] time_now;
        logic        load_rejected;
    } t_result;

endpackage

// ----- rtl/pps_entry_ram.sv -----
module pps_entry_ram
    import pps_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pps_result_buf.sv -----
module pps_result_buf
    import pps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    input  t_result i_push_res,
    output logic    o_push_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;
    logic    push;

    assign o_push_ready = !r_valid || i_ready;
    assign push         = i_push_valid && o_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (push) begin
            r_res <= i_push_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/preemptive_priority_scheduler_unit.sv -----
// Preemptive priority scheduler, one request per load or tick.
// Input channel: i_in_valid / o_in_ready carry a request; i_op selects a job
// load (job fields used) or one time tick (job fields ignored).
// Output channel: o_out_valid / i_out_ready carry exactly one result per
// request, in request order.
// Operation: a load writes its entry and then hands on its result. A tick
// walks the loaded entries, since the entry RAM has one registered read port:
// it reads the loaded entries one per cycle, releasing arrived jobs and
// tracking the lowest priority number, then serves the chosen job and writes
// its remaining time back, and then finishes the waiting time. A new request
// is taken only in idle, once the previous result has gone to the output
// register.
// A finished result sits in an output register; the next request is taken
// while it waits, and its result holds internally until the receiver takes
// the earlier one. A stalled receiver therefore stops intake after one
// request.
// Reset (synchronous, active low) empties the job store, clears all ready
// bits and sets the timer to zero; no result is pending afterward.
module preemptive_priority_scheduler_unit
    import pps_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_job_label,
    input  logic [15:0] i_burst_len,
    input  logic [31:0] i_arrive_at,
    input  logic [7:0]  i_urgency,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ran,
    output logic [7:0]  o_served_label,
    output logic        o_first_service,
    output logic [31:0] o_response_ticks,
    output logic        o_finished,
    output logic [31:0] o_turnaround_ticks,
    output logic [31:0] o_waiting_ticks,
    output logic [31:0] o_time_now,
    output logic        o_load_rejected
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_FIN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rp, n_rp;
    logic [MAX_JOBS-1:0] r_ready, n_ready;
    logic [31:0]         r_timer, n_timer;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_chk_vld, n_chk_vld;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_found, n_found;
    logic [AW-1:0]       r_best_idx, n_best_idx;
    t_entry              r_best, n_best;
    t_result             r_res, n_res;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    t_entry        ram_rdata;

    logic          push_valid;
    logic          push_ready;
    t_result       out_res;

    logic          rel;
    logic          rdy;
    logic [15:0]   rem_next;
    logic [31:0]   timer_next;
    logic [31:0]   wait_diff;

    pps_entry_ram #(
        .DEPTH (MAX_JOBS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    pps_result_buf u_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_res   (r_res),
        .o_push_ready (push_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (out_res)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign timer_next = (r_timer == TIMER_MAX) ? r_timer : r_timer + 32'd1;
    assign rem_next   = r_best.remaining - 16'd1;
    assign wait_diff  = r_res.turnaround_ticks - {16'd0, r_best.burst};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rp       = r_rp;
        n_ready    = r_ready;
        n_timer    = r_timer;
        n_idx      = r_idx;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = r_best_idx;
        ram_wdata  = r_best;
        ram_re     = 1'b0;
        push_valid = 1'b0;
        rel        = 1'b0;
        rdy        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_LOAD) begin
                        n_res          = '0;
                        n_res.time_now = r_timer;
                        if (r_count == CW'(MAX_JOBS) || i_burst_len == 16'd0) begin
                            n_res.load_rejected = 1'b1;
                        end else begin
                            ram_we              = 1'b1;
                            ram_waddr           = r_count[AW-1:0];
                            ram_wdata.label     = i_job_label;
                            ram_wdata.burst     = i_burst_len;
                            ram_wdata.remaining = i_burst_len;
                            ram_wdata.arrival   = i_arrive_at;
                            ram_wdata.urgency   = i_urgency;
                            n_count             = r_count + CW'(1);
                        end
                        n_state = S_DONE;
                    end else begin
                        n_idx     = '0;
                        n_chk_vld = 1'b0;
                        n_found   = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx < r_count) begin
                    ram_re    = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_idx[AW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    rel = (CW'(r_chk_idx) == r_rp) && (ram_rdata.arrival <= r_timer);
                    rdy = r_ready[r_chk_idx] || rel;
                    if (rel) begin
                        n_ready[r_chk_idx] = 1'b1;
                        n_rp               = r_rp + CW'(1);
                    end
                    if (rdy && (!r_found || ram_rdata.urgency < r_best.urgency)) begin
                        n_found    = 1'b1;
                        n_best_idx = r_chk_idx;
                        n_best     = ram_rdata;
                    end
                end else if (r_idx >= r_count) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res          = '0;
                n_res.time_now = timer_next;
                n_timer        = timer_next;
                if (r_found) begin
                    n_res.ran          = 1'b1;
                    n_res.served_label = r_best.label;
                    if (r_best.remaining == r_best.burst) begin
                        n_res.first_service  = 1'b1;
                        n_res.response_ticks = r_timer - r_best.arrival;
                    end
                    if (rem_next == 16'd0) begin
                        n_res.finished         = 1'b1;
                        n_res.turnaround_ticks = timer_next - r_best.arrival;
                        n_ready[r_best_idx]    = 1'b0;
                    end
                    ram_we              = 1'b1;
                    ram_wdata.remaining = rem_next;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_res.finished && r_res.turnaround_ticks >= {16'd0, r_best.burst}) begin
                    n_res.waiting_ticks = wait_diff;
                end else begin
                    n_res.waiting_ticks = 32'd0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rp      <= '0;
            r_ready   <= '0;
            r_timer   <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rp      <= n_rp;
            r_ready   <= n_ready;
            r_timer   <= n_timer;
            r_idx     <= n_idx;
            r_chk_vld <= n_chk_vld;
            r_found   <= n_found;
        end
        r_chk_idx  <= n_chk_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_res      <= n_res;
    end

    assign o_ran              = out_res.ran;
    assign o_served_label     = out_res.served_label;
    assign o_first_service    = out_res.first_service;
    assign o_response_ticks   = out_res.response_ticks;
    assign o_finished         = out_res.finished;
    assign o_turnaround_ticks = out_res.turnaround_ticks;
    assign o_waiting_ticks    = out_res.waiting_ticks;
    assign o_time_now         = out_res.time_now;
    assign o_load_rejected    = out_res.load_rejected;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pps_pkg::*;

    localparam int JOB_SLOTS = 16;

    typedef struct {
        logic        op;
        logic [7:0]  label;
        logic [15:0] burst;
        logic [31:0] arrival;
        logic [7:0]  urgency;
    } t_sched_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_op = OP_LOAD;
    logic [7:0]  i_job_label = '0;
    logic [15:0] i_burst_len = '0;
    logic [31:0] i_arrive_at = '0;
    logic [7:0]  i_urgency = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_ran;
    logic [7:0]  o_served_label;
    logic        o_first_service;
    logic [31:0] o_response_ticks;
    logic        o_finished;
    logic [31:0] o_turnaround_ticks;
    logic [31:0] o_waiting_ticks;
    logic [31:0] o_time_now;
    logic        o_load_rejected;

    t_sched_req  pending_reqs[$];
    t_sched_req  next_req;
    t_result     expected_results[$];
    t_result     want;

    t_entry                 job_store [JOB_SLOTS];
    logic [JOB_SLOTS-1:0]   ready_bits = '0;
    int                     jobs_loaded = 0;
    int                     release_idx = 0;
    logic [31:0]            sched_timer = '0;

    logic [31:0] gen_ticks = '0;
    int          gen_slots = 0;
    int          req_count = 0;
    int          err_count = 0;
    logic        in_fire = 1'b0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        quiet_window;

    assign quiet_window = (req_count >= 900) && (req_count < 1200);

    preemptive_priority_scheduler_unit #(
        .MAX_JOBS(JOB_SLOTS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_job_label        (i_job_label),
        .i_burst_len        (i_burst_len),
        .i_arrive_at        (i_arrive_at),
        .i_urgency          (i_urgency),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_ran              (o_ran),
        .o_served_label     (o_served_label),
        .o_first_service    (o_first_service),
        .o_response_ticks   (o_response_ticks),
        .o_finished         (o_finished),
        .o_turnaround_ticks (o_turnaround_ticks),
        .o_waiting_ticks    (o_waiting_ticks),
        .o_time_now         (o_time_now),
        .o_load_rejected    (o_load_rejected)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result sched_predict(input logic op, input logic [7:0] lbl,
                                              input logic [15:0] bl, input logic [31:0] arr,
                                              input logic [7:0] urg);
        t_result     r;
        int          pick;
        int          i;
        logic [31:0] ta;
        r = '0;
        if (op == OP_LOAD) begin
            if (jobs_loaded >= JOB_SLOTS || bl == 16'd0) begin
                r.load_rejected = 1'b1;
            end else begin
                job_store[jobs_loaded].label     = lbl;
                job_store[jobs_loaded].burst     = bl;
                job_store[jobs_loaded].remaining = bl;
                job_store[jobs_loaded].arrival   = arr;
                job_store[jobs_loaded].urgency   = urg;
                ready_bits[jobs_loaded]          = 1'b0;
                jobs_loaded++;
            end
            r.time_now = sched_timer;
            return r;
        end
        while (release_idx < jobs_loaded && job_store[release_idx].arrival <= sched_timer) begin
            ready_bits[release_idx] = 1'b1;
            release_idx++;
        end
        pick = -1;
        for (i = 0; i < jobs_loaded; i++) begin
            if (ready_bits[i] && (pick < 0 || job_store[i].urgency < job_store[pick].urgency))
                pick = i;
        end
        if (pick >= 0) begin
            r.ran          = 1'b1;
            r.served_label = job_store[pick].label;
            if (job_store[pick].remaining == job_store[pick].burst) begin
                r.first_service  = 1'b1;
                r.response_ticks = sched_timer - job_store[pick].arrival;
            end
            job_store[pick].remaining = job_store[pick].remaining - 16'd1;
        end
        if (sched_timer != TIMER_MAX)
            sched_timer = sched_timer + 32'd1;
        if (pick >= 0 && job_store[pick].remaining == 16'd0) begin
            ta                 = sched_timer - job_store[pick].arrival;
            r.finished         = 1'b1;
            r.turnaround_ticks = ta;
            r.waiting_ticks    = (ta >= {16'd0, job_store[pick].burst}) ?
                                 ta - {16'd0, job_store[pick].burst} : 32'd0;
            ready_bits[pick]   = 1'b0;
        end
        r.time_now = sched_timer;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    task automatic push_load(input logic [7:0] lbl, input logic [15:0] bl,
                             input logic [31:0] arr, input logic [7:0] urg);
        t_sched_req req;
        req.op      = OP_LOAD;
        req.label   = lbl;
        req.burst   = bl;
        req.arrival = arr;
        req.urgency = urg;
        pending_reqs.push_back(req);
        if (bl != 16'd0 && gen_slots < JOB_SLOTS)
            gen_slots++;
    endtask

    task automatic push_tick();
        t_sched_req req;
        req.op      = OP_TICK;
        req.label   = 8'($urandom);
        req.burst   = 16'($urandom);
        req.arrival = $urandom;
        req.urgency = 8'($urandom);
        pending_reqs.push_back(req);
        gen_ticks++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_reqs.size() != 0 && (quiet_window || $urandom_range(0, 99) >= 8)) begin
                next_req = pending_reqs.pop_front();
                i_in_valid  <= 1'b1;
                i_op        <= next_req.op;
                i_job_label <= next_req.label;
                i_burst_len <= next_req.burst;
                i_arrive_at <= next_req.arrival;
                i_urgency   <= next_req.urgency;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && req_count >= 400) begin
            i_out_ready <= 1'b0;
            hold_left   <= 300;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= quiet_window || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                check_field("ran", 32'(o_ran), 32'(want.ran));
                check_field("served_label", 32'(o_served_label), 32'(want.served_label));
                check_field("first_service", 32'(o_first_service), 32'(want.first_service));
                check_field("response_ticks", o_response_ticks, want.response_ticks);
                check_field("finished", 32'(o_finished), 32'(want.finished));
                check_field("turnaround_ticks", o_turnaround_ticks, want.turnaround_ticks);
                check_field("waiting_ticks", o_waiting_ticks, want.waiting_ticks);
                check_field("time_now", o_time_now, want.time_now);
                check_field("load_rejected", 32'(o_load_rejected), 32'(want.load_rejected));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_results.push_back(sched_predict(i_op, i_job_label, i_burst_len,
                                                     i_arrive_at, i_urgency));
            req_count <= req_count + 1;
        end
    end

    initial begin : stimulus
        int n;
        push_tick();
        push_load(8'hFF, 16'd0, 32'hFFFF_FFFF, 8'hFF);
        push_load(8'h00, 16'd1, 32'd0, 8'hFF);
        push_load(8'hA5, 16'd3, 32'd1, 8'h00);
        push_load(8'h5A, 16'd2, 32'd2, 8'h00);
        repeat (7) push_tick();
        push_load(8'h01, 16'd2, gen_ticks + 32'd6, 8'h05);
        push_load(8'h02, 16'd1, 32'd0, 8'h00);
        repeat (9) push_tick();
        for (n = 0; n < 1830; n++) begin
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 4) != 0) begin
                        push_tick();
                    end else if (gen_slots < JOB_SLOTS - 1) begin
                        push_load(8'($urandom),
                                  ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 4))
                                                              : 16'($urandom_range(1, 120)),
                                  gen_ticks + $urandom_range(0, 200),
                                  $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                                       : 8'($urandom_range(0, 255)));
                    end else if (gen_slots == JOB_SLOTS - 1) begin
                        push_load(8'($urandom), 16'hFFFF, gen_ticks + $urandom_range(0, 50),
                                  8'hFF);
                    end else begin
                        push_load(8'($urandom), 16'($urandom), $urandom, 8'($urandom));
                    end
                end
                1: begin
                    if ($urandom_range(0, 3) == 0)
                        push_load(8'($urandom),
                                  (gen_slots < JOB_SLOTS) ? 16'd0 : 16'($urandom),
                                  $urandom, 8'($urandom));
                    else
                        push_tick();
                end
                default: push_tick();
            endcase
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
